// ----- hdl/at_response_framer_macros.svh -----
// ----------------------------------------------------------------------------
// at_response_framer_macros
// assertion macros used by the checker file atrf_checker.sv
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_FRAMER_MACROS_SVH
`define AT_RESPONSE_FRAMER_MACROS_SVH

// checked only while out of reset
`define ATRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in and out of reset
`define ATRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/atrf_pkg.sv -----
// ----------------------------------------------------------------------------
// atrf_pkg
// types, constants and keyword match functions of the response framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atrf_pkg;

  localparam int WIN_DEPTH   = 10;
  localparam int FILL_W      = 4;
  localparam int KW_W        = 8 * (WIN_DEPTH + 1);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SEP = 8'h7C;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_RESP  = 2'd1;
  localparam kind_t KIND_UNSOL = 2'd2;

  typedef enum logic {
    OP_PUSH,
    OP_LINE_END
  } op_t;

  // one queue entry: the commands caused by one input word
  typedef struct packed {
    op_t        op0;
    logic [7:0] byte0;
    logic       two;
    logic [7:0] byte1;
  } cmd_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [KW_W-1:0] KW_CONNECT = KW_W'("CONNECT");
  localparam logic [KW_W-1:0] KW_OK      = KW_W'("OK");
  localparam logic [KW_W-1:0] KW_BUSY    = KW_W'("BUSY");
  localparam logic [KW_W-1:0] KW_CMS     = KW_W'("+CMS ERROR:");
  localparam logic [KW_W-1:0] KW_CME     = KW_W'("+CME ERROR:");
  localparam logic [KW_W-1:0] KW_ERROR   = KW_W'("ERROR");
  localparam logic [KW_W-1:0] KW_NOCARR  = KW_W'("NO CARRIER");
  localparam logic [KW_W-1:0] KW_NOANS   = KW_W'("NO ANSWER");
  localparam logic [KW_W-1:0] KW_NODIAL  = KW_W'("NO DIALTONE");
  localparam logic [KW_W-1:0] KW_TAG     = KW_W'("+EMGSMS:");

  // word ends with b, earlier characters in the window (index 0 newest)
  function automatic logic ends_with(input logic [8*WIN_DEPTH-1:0] win,
                                     input logic [FILL_W-1:0]    fill,
                                     input logic [7:0]           b,
                                     input logic [KW_W-1:0]      word,
                                     input int                   len);
    logic hit;
    hit = (b == word[7:0]) && (int'(fill) >= len - 1);
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if ((j < len - 1) && (win[8*j +: 8] != word[8*(j+1) +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic final_hit(input logic [8*WIN_DEPTH-1:0] win,
                                     input logic [FILL_W-1:0]    fill,
                                     input logic [7:0]           b);
    return ends_with(win, fill, b, KW_CONNECT, 7)  |
           ends_with(win, fill, b, KW_OK, 2)       |
           ends_with(win, fill, b, KW_BUSY, 4)     |
           ends_with(win, fill, b, KW_CMS, 11)     |
           ends_with(win, fill, b, KW_CME, 11)     |
           ends_with(win, fill, b, KW_ERROR, 5)    |
           ends_with(win, fill, b, KW_NOCARR, 10)  |
           ends_with(win, fill, b, KW_NOANS, 9)    |
           ends_with(win, fill, b, KW_NODIAL, 11);
  endfunction

  function automatic logic tag_hit(input logic [8*WIN_DEPTH-1:0] win,
                                   input logic [FILL_W-1:0]    fill,
                                   input logic [7:0]           b);
    return ends_with(win, fill, b, KW_TAG, 8);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/at_response_framer.sv -----
// an accepted input word passes through the command queue, then the output register
// throughput: one input word per cycle while each causes at most one output and out_tready is high;
//   output rate is one word per cycle while out_tready is high, set by the single back command unit
// a held cr followed by a byte other than cr, lf or nul yields two output words, the cr first
// reset: synchronous active-low rst_n clears queue, window, flags and valid
// ----------------------------------------------------------------------------
// at_response_framer
// splits a modem response stream into lines and frames them into packets
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module at_response_framer #(
  parameter int QUEUE_DEPTH = atrf_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // in_byte
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [1:0] out_tuser,  // out_kind
  output logic       out_tlast   // last_of_run
);
  import atrf_pkg::*;

  q_stat_t    q_stat;
  cmd_entry_t q_entry;
  cmd_entry_t q_head;
  logic       q_push;
  logic       q_pop;

  atrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  atrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  atrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/atrf_front.sv -----
// ----------------------------------------------------------------------------
// atrf_front
// accepts input words, resolves held cr and queues line commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atrf_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [7:0]            in_tdata,   // in_byte
  input  atrf_pkg::q_stat_t     q_stat,
  output logic                  q_push,
  output atrf_pkg::cmd_entry_t  q_entry
);
  import atrf_pkg::*;

  logic cr_held_r;
  logic cr_held_nxt;
  logic wr;
  logic accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && wr;

  always_comb begin
    cr_held_nxt   = cr_held_r;
    wr            = 1'b0;
    q_entry.op0   = OP_PUSH;
    q_entry.byte0 = in_tdata;
    q_entry.two   = 1'b0;
    q_entry.byte1 = in_tdata;
    if (in_tdata == CH_NUL) begin
      wr = 1'b0;
    end else if (cr_held_r) begin
      wr = 1'b1;
      if (in_tdata == CH_LF) begin
        q_entry.op0 = OP_LINE_END;
        cr_held_nxt = 1'b0;
      end else begin
        q_entry.byte0 = CH_CR;
        q_entry.two   = (in_tdata != CH_CR);
        cr_held_nxt   = (in_tdata == CH_CR);
      end
    end else if (in_tdata == CH_CR) begin
      cr_held_nxt = 1'b1;
    end else begin
      wr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_held_r <= 1'b0;
    end else if (accept) begin
      cr_held_r <= cr_held_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/atrf_queue.sv -----
// ----------------------------------------------------------------------------
// atrf_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atrf_queue #(
  parameter int DEPTH = atrf_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  atrf_pkg::cmd_entry_t  push_entry,
  input  wire                   pop,
  output atrf_pkg::cmd_entry_t  head,
  output atrf_pkg::q_stat_t     stat
);
  import atrf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wptr_nxt;
  logic [PTR_W-1:0] rptr_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/atrf_back.sv -----
// ----------------------------------------------------------------------------
// atrf_back
// runs queued commands: keyword window, line flags and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atrf_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  atrf_pkg::cmd_entry_t  head,
  input  atrf_pkg::q_stat_t     q_stat,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [7:0]            out_tdata,  // out_byte
  output logic [1:0]            out_tuser,  // out_kind
  output logic                  out_tlast   // last_of_run
);
  import atrf_pkg::*;

  logic [8*WIN_DEPTH-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   final_r, final_nxt;
  logic                   tag_r, tag_nxt;
  logic                   sub_r, sub_nxt;
  logic                   valid_r, valid_nxt;
  logic [7:0]             data_r, data_nxt;
  kind_t                  kind_r, kind_nxt;
  logic                   last_r, last_nxt;
  logic                   adv;
  logic                   go;
  logic                   cur_push;
  logic [7:0]             cur_byte;
  logic                   cur_last;

  assign adv      = !valid_r || out_tready;
  assign go       = !q_stat.empty && adv;
  assign cur_push = sub_r || (head.op0 == OP_PUSH);
  assign cur_byte = sub_r ? head.byte1 : head.byte0;
  assign cur_last = sub_r || !head.two;
  assign q_pop    = go && cur_last;

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    final_nxt = final_r;
    tag_nxt   = tag_r;
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    if (go) begin
      sub_nxt = !cur_last;
      if (cur_push) begin
        final_nxt = final_r | final_hit(win_r, fill_r, cur_byte);
        tag_nxt   = tag_r | tag_hit(win_r, fill_r, cur_byte);
        win_nxt   = {win_r[8*(WIN_DEPTH-1)-1:0], cur_byte};
        fill_nxt  = (fill_r == FILL_W'(WIN_DEPTH)) ? fill_r : fill_r + 1'b1;
        valid_nxt = 1'b1;
        data_nxt  = cur_byte;
        kind_nxt  = KIND_BYTE;
        last_nxt  = cur_last;
      end else begin
        valid_nxt = (fill_r != '0);
        last_nxt  = 1'b1;
        if (final_r) begin
          data_nxt = CH_NUL;
          kind_nxt = KIND_RESP;
        end else if (tag_r) begin
          data_nxt = CH_NUL;
          kind_nxt = KIND_UNSOL;
        end else begin
          data_nxt = CH_SEP;
          kind_nxt = KIND_BYTE;
        end
        win_nxt   = '0;
        fill_nxt  = '0;
        final_nxt = 1'b0;
        tag_nxt   = 1'b0;
      end
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      final_r <= 1'b0;
      tag_r   <= 1'b0;
      sub_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      final_r <= final_nxt;
      tag_r   <= tag_nxt;
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ----- hdl/atrf_checker.sv -----
// ----------------------------------------------------------------------------
// atrf_checker
// port-level checks of the response framer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_framer_macros.svh"

module atrf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tready,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire [1:0] out_tuser,
  input wire       out_tlast
);
  import atrf_pkg::*;

  `ATRF_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")
  `ATRF_ASSERT_RST(a_reset_ready, !rst_n |=> in_tready, "input not ready after reset")
  `ATRF_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output word changed")
  `ATRF_ASSERT(a_marker, out_tvalid && (out_tuser != KIND_BYTE) |-> (out_tdata == CH_NUL) && out_tlast, "end marker not alone")
  `ATRF_ASSERT(a_first_cr, out_tvalid && !out_tlast |-> (out_tuser == KIND_BYTE) && (out_tdata == CH_CR), "non-last word is not a held cr")

endmodule

bind at_response_framer atrf_checker u_atrf_checker (.*);

`default_nettype wire
